// File: hdl/rde_pkg.sv
`timescale 1ns / 1ps
package rde_pkg;

   localparam int OPCODE_W  = 3;
   localparam int VALUE_W   = 16;
   localparam int ELEMENT_W = 16;
   localparam int ERR_W     = 2;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [ERR_W-1:0]    err_type;

   localparam opcode_type OP_CLEAR   = 3'd0;
   localparam opcode_type OP_PUSH    = 3'd1;
   localparam opcode_type OP_REVERSE = 3'd2;
   localparam opcode_type OP_DELETE  = 3'd3;
   localparam opcode_type OP_EMIT    = 3'd4;

   localparam err_type ERR_NONE     = 2'd0;
   localparam err_type ERR_EMPTY    = 2'd1;
   localparam err_type ERR_OVERFLOW = 2'd2;

endpackage

// File: hdl/reversible_deque_engine.sv
`timescale 1ns / 1ps
// A command is taken when req_valid is high and req_stall is low. An emit that finds
// an error or an empty list puts its single result on the output in the cycle after
// it is taken. An emit of n elements streams them from the store's read port one per
// cycle while the output is not stalled, via the read address, RAM read and output
// registers; commands stall until the drain has left the read stage. Reset clears
// pointers, count, direction and error; the store itself is not initialized.
module reversible_deque_engine #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rde_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [rde_pkg::VALUE_W-1:0]      req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rde_pkg::ELEMENT_W-1:0]    rsp_element,
   output logic [rde_pkg::ERR_W-1:0]        rsp_error_code,
   output logic                             rsp_empty_list,
   output logic                             rsp_last
);

   // Bits above the output element width can never be seen, so they are not stored.
   localparam int STORE_W = (VALUE_WIDTH < rde_pkg::ELEMENT_W) ? VALUE_WIDTH
                                                              : rde_pkg::ELEMENT_W;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = CNT_W + 1;

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [PTR_W-1:0]          head_ff, head_in;
   logic                      rev_ff, rev_in;
   rde_pkg::err_type          err_ff, err_in;
   logic [CNT_W-1:0]          remain_ff, remain_in;
   logic [PTR_W-1:0]          addr_ff, addr_in;
   logic                      dir_ff, dir_in;
   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_last_ff, s1_last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [rde_pkg::ELEMENT_W-1:0] rsp_element_ff, rsp_element_in;
   rde_pkg::err_type          rsp_err_ff, rsp_err_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      accept;
   logic                      out_free;
   logic                      rd_en;
   logic                      s1_adv;
   logic                      wr_en;
   logic [PTR_W-1:0]          wr_addr;
   logic [STORE_W-1:0]        rd_data;
   logic [SUM_W-1:0]          push_sum;
   logic [SUM_W-1:0]          tail_sum;
   logic [PTR_W-1:0]          tail_ptr;
   logic [PTR_W-1:0]          head_next;
   logic [PTR_W-1:0]          addr_up;
   logic [PTR_W-1:0]          addr_down;
   logic                      single_load;
   rde_pkg::err_type          single_err;
   logic                      single_empty;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (remain_ff != '0) || s1_valid_ff || !out_free;
   assign accept    = req_valid && !req_stall;
   // A new read replaces the RAM output register, so it waits until that word moves on.
   assign rd_en     = (remain_ff != '0) && (!s1_valid_ff || out_free);
   assign s1_adv    = s1_valid_ff && out_free;

   assign push_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign wr_addr  = (push_sum >= SUM_W'(DEPTH)) ? PTR_W'(push_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(push_sum);
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff) - SUM_W'(1);
   assign tail_ptr = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(tail_sum);

   assign head_next = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
   assign addr_up   = (addr_ff == PTR_W'(DEPTH - 1)) ? '0 : addr_ff + PTR_W'(1);
   assign addr_down = (addr_ff == '0) ? PTR_W'(DEPTH - 1) : addr_ff - PTR_W'(1);

   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      rev_in       = rev_ff;
      err_in       = err_ff;
      remain_in    = remain_ff;
      addr_in      = addr_ff;
      dir_in       = dir_ff;
      wr_en        = 1'b0;
      single_load  = 1'b0;
      single_err   = rde_pkg::ERR_NONE;
      single_empty = 1'b0;

      if (rd_en) begin
         remain_in = remain_ff - CNT_W'(1);
         addr_in   = dir_ff ? addr_down : addr_up;
      end

      if (accept) begin
         case (req_opcode)
            rde_pkg::OP_CLEAR: begin
               count_in = '0;
               head_in  = '0;
               rev_in   = 1'b0;
               err_in   = rde_pkg::ERR_NONE;
            end
            rde_pkg::OP_PUSH: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  if (err_ff == rde_pkg::ERR_NONE) begin
                     err_in = rde_pkg::ERR_OVERFLOW;
                  end
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            rde_pkg::OP_REVERSE: begin
               rev_in = !rev_ff;
            end
            rde_pkg::OP_DELETE: begin
               if (err_ff == rde_pkg::ERR_NONE) begin
                  if (count_ff == '0) begin
                     err_in = rde_pkg::ERR_EMPTY;
                  end else begin
                     // Seen in reverse, the front is the stored back, so head stays.
                     if (!rev_ff) begin
                        head_in = head_next;
                     end
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            rde_pkg::OP_EMIT: begin
               if (err_ff != rde_pkg::ERR_NONE) begin
                  single_load = 1'b1;
                  single_err  = err_ff;
               end else if (count_ff == '0) begin
                  single_load  = 1'b1;
                  single_empty = 1'b1;
               end else begin
                  remain_in = count_ff;
                  addr_in   = rev_ff ? tail_ptr : head_ff;
                  dir_in    = rev_ff;
                  count_in  = '0;
                  head_in   = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      if (rd_en) begin
         s1_valid_in = 1'b1;
         s1_last_in  = (remain_ff == CNT_W'(1));
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_element_in = rsp_element_ff;
      rsp_err_in     = rsp_err_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_last_in    = rsp_last_ff;
      if (s1_adv) begin
         rsp_valid_in   = 1'b1;
         rsp_element_in = rde_pkg::ELEMENT_W'(rd_data);
         rsp_err_in     = rde_pkg::ERR_NONE;
         rsp_empty_in   = 1'b0;
         rsp_last_in    = s1_last_ff;
      end else if (single_load) begin
         rsp_valid_in   = 1'b1;
         rsp_element_in = '0;
         rsp_err_in     = single_err;
         rsp_empty_in   = single_empty;
         rsp_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_ff      <= '0;
         rev_ff       <= 1'b0;
         err_ff       <= rde_pkg::ERR_NONE;
         remain_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         rev_ff       <= rev_in;
         err_ff       <= err_in;
         remain_ff    <= remain_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      dir_ff         <= dir_in;
      s1_last_ff     <= s1_last_in;
      rsp_element_ff <= rsp_element_in;
      rsp_err_ff     <= rsp_err_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_last_ff    <= rsp_last_in;
   end

   rde_ram #(
      .WIDTH (STORE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (STORE_W'(req_value)),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_element    = rsp_element_ff;
   assign rsp_error_code = rsp_err_ff;
   assign rsp_empty_list = rsp_empty_ff;
   assign rsp_last       = rsp_last_ff;

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count exceeds store depth");

   a_head_range : assert property (@(posedge clock) disable iff (reset)
      head_ff <= PTR_W'(DEPTH - 1))
      else $error("head pointer outside store");

   a_drain_list_empty : assert property (@(posedge clock) disable iff (reset)
      (remain_ff != '0) |-> (count_ff == '0) && (head_ff == '0))
      else $error("list not cleared while draining");

   a_no_read_overwrite : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> $stable(rd_data))
      else $error("read stage word overwritten while output stalled");

   a_last_ends_drain : assert property (@(posedge clock) disable iff (reset)
      (rd_en && remain_ff == CNT_W'(1)) |=> (remain_ff == '0) && s1_last_ff)
      else $error("drain did not end on its last word");

endmodule

// File: hdl/rde_ram.sv
`timescale 1ns / 1ps
module rde_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int STORE_DEPTH = 64;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int EXP_DEPTH   = 256;
   localparam rde_pkg::opcode_type OP_UNUSED_LO = 3'd5;
   localparam rde_pkg::opcode_type OP_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [rde_pkg::ELEMENT_W-1:0] element;
      rde_pkg::err_type              error_code;
      logic                          empty_list;
      logic                          last;
   } drain_word_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [rde_pkg::OPCODE_W-1:0]  req_opcode;
   logic [rde_pkg::VALUE_W-1:0]   req_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [rde_pkg::ELEMENT_W-1:0] rsp_element;
   logic [rde_pkg::ERR_W-1:0]     rsp_error_code;
   logic                          rsp_empty_list;
   logic                          rsp_last;

   // Shadow copy of the deque, updated as each command word is accepted.
   logic [rde_pkg::VALUE_W-1:0] list_store [STORE_DEPTH];
   int unsigned                 list_head;
   int unsigned                 list_count;
   bit                          list_reversed;
   rde_pkg::err_type            list_error;

   // Expected result words, kept in a ring; the 8-bit indexes wrap with it.
   drain_word_type exp_words [EXP_DEPTH];
   logic [7:0]     exp_wr;
   logic [7:0]     exp_rd;
   int             words_sent;
   int             failures;
   int             send_idle_pct;
   int             recv_idle_pct;

   reversible_deque_engine u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_element    (rsp_element),
      .rsp_error_code (rsp_error_code),
      .rsp_empty_list (rsp_empty_list),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("FAIL reversible_deque_engine");
      $finish;
   end

   function automatic void add_expected(drain_word_type w);
      exp_words[exp_wr] = w;
      exp_wr = exp_wr + 8'd1;
   endfunction

   function automatic void predict_command(rde_pkg::opcode_type op,
                                           logic [rde_pkg::VALUE_W-1:0] val);
      drain_word_type w;
      int unsigned off;
      case (op)
         rde_pkg::OP_CLEAR: begin
            list_head = 0;
            list_count = 0;
            list_reversed = 1'b0;
            list_error = rde_pkg::ERR_NONE;
         end
         rde_pkg::OP_PUSH: begin
            if (list_count >= STORE_DEPTH) begin
               if (list_error == rde_pkg::ERR_NONE) list_error = rde_pkg::ERR_OVERFLOW;
            end else begin
               list_store[STORE_AW'((list_head + list_count) % STORE_DEPTH)] = val;
               list_count++;
            end
         end
         rde_pkg::OP_REVERSE: list_reversed = !list_reversed;
         rde_pkg::OP_DELETE: begin
            // Once an error is recorded, deletes have no effect until a clear.
            if (list_error == rde_pkg::ERR_NONE) begin
               if (list_count == 0) begin
                  list_error = rde_pkg::ERR_EMPTY;
               end else begin
                  if (!list_reversed) list_head = (list_head + 1) % STORE_DEPTH;
                  list_count--;
               end
            end
         end
         rde_pkg::OP_EMIT: begin
            if (list_error != rde_pkg::ERR_NONE) begin
               w = '{element: '0, error_code: list_error, empty_list: 1'b0, last: 1'b1};
               add_expected(w);
            end else if (list_count == 0) begin
               w = '{element: '0, error_code: rde_pkg::ERR_NONE, empty_list: 1'b1,
                     last: 1'b1};
               add_expected(w);
            end else begin
               for (int unsigned i = 0; i < list_count; i++) begin
                  off = list_reversed ? (list_count - 1 - i) : i;
                  w.element = list_store[STORE_AW'((list_head + off) % STORE_DEPTH)];
                  w.error_code = rde_pkg::ERR_NONE;
                  w.empty_list = 1'b0;
                  w.last = (i + 1 == list_count);
                  add_expected(w);
               end
               list_count = 0;
               list_head = 0;
            end
         end
         default: ;
      endcase
   endfunction

   // Called right after a rising edge; returns at the edge that accepts the word.
   task automatic send_word(input rde_pkg::opcode_type op,
                            input logic [rde_pkg::VALUE_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_opcode <= rde_pkg::OPCODE_W'($urandom);
         req_value <= rde_pkg::VALUE_W'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_command(op, val);
      words_sent++;
   endtask

   function automatic logic [rde_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return rde_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      drain_word_type w;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (exp_rd == exp_wr) begin
            $error("unexpected result word: element %h error_code %0d empty_list %0d last %0d",
                   rsp_element, rsp_error_code, rsp_empty_list, rsp_last);
            failures++;
         end else begin
            w = exp_words[exp_rd];
            exp_rd = exp_rd + 8'd1;
            if (rsp_element !== w.element) begin
               $error("rsp_element mismatch: expected %h, got %h", w.element, rsp_element);
               failures++;
            end
            if (rsp_error_code !== w.error_code) begin
               $error("rsp_error_code mismatch: expected %0d, got %0d",
                      w.error_code, rsp_error_code);
               failures++;
            end
            if (rsp_empty_list !== w.empty_list) begin
               $error("rsp_empty_list mismatch: expected %0d, got %0d",
                      w.empty_list, rsp_empty_list);
               failures++;
            end
            if (rsp_last !== w.last) begin
               $error("rsp_last mismatch: expected %0d, got %0d", w.last, rsp_last);
               failures++;
            end
         end
      end
   end

   task automatic test_empty_and_errors();
      send_word(rde_pkg::OP_EMIT, 16'h0000);
      send_word(rde_pkg::OP_DELETE, 16'hFFFF);
      send_word(rde_pkg::OP_DELETE, 16'h0000);
      // A push still lands while an error is recorded; the emit reports the error.
      send_word(rde_pkg::OP_PUSH, 16'hFFFF);
      send_word(rde_pkg::OP_EMIT, 16'hFFFF);
      send_word(OP_UNUSED_LO, 16'hA5A5);
      send_word(OP_UNUSED_HI, 16'h5A5A);
      send_word(rde_pkg::OP_CLEAR, 16'hFFFF);
      send_word(rde_pkg::OP_EMIT, 16'h0000);
   endtask

   task automatic test_push_reverse_emit();
      send_word(rde_pkg::OP_PUSH, 16'h0000);
      send_word(rde_pkg::OP_PUSH, 16'hFFFF);
      send_word(rde_pkg::OP_PUSH, pick_value());
      send_word(rde_pkg::OP_REVERSE, 16'h0000);
      send_word(rde_pkg::OP_EMIT, 16'h0000);
      send_word(rde_pkg::OP_EMIT, 16'h0000);
      send_word(rde_pkg::OP_PUSH, 16'h1111);
      send_word(rde_pkg::OP_PUSH, 16'h2222);
      send_word(rde_pkg::OP_PUSH, 16'h3333);
      send_word(rde_pkg::OP_DELETE, 16'h0000);
      send_word(rde_pkg::OP_REVERSE, 16'h0000);
      send_word(rde_pkg::OP_DELETE, 16'h0000);
      send_word(rde_pkg::OP_EMIT, 16'h0000);
   endtask

   // Fill the store, move the head so the ring wraps, then overflow it.
   task automatic test_full_store();
      send_word(rde_pkg::OP_CLEAR, 16'h0000);
      repeat (STORE_DEPTH) send_word(rde_pkg::OP_PUSH, pick_value());
      send_word(rde_pkg::OP_DELETE, 16'h0000);
      send_word(rde_pkg::OP_DELETE, 16'h0000);
      repeat (3) send_word(rde_pkg::OP_PUSH, pick_value());
      send_word(rde_pkg::OP_DELETE, 16'h0000);
      send_word(rde_pkg::OP_EMIT, 16'h0000);
      send_word(rde_pkg::OP_CLEAR, 16'h0000);
   endtask

   task automatic test_random_lists(input int budget);
      int start;
      int kind;
      int n;
      int room;
      start = words_sent;
      while (words_sent - start < budget) begin
         kind = $urandom_range(99);
         if (kind < 20) begin
            repeat ($urandom_range(1, 3))
               send_word(rde_pkg::opcode_type'($urandom_range(7)),
                         rde_pkg::VALUE_W'($urandom));
         end else begin
            if (list_error != rde_pkg::ERR_NONE || $urandom_range(3) == 0)
               send_word(rde_pkg::OP_CLEAR, rde_pkg::VALUE_W'($urandom));
            n = (kind < 30) ? $urandom_range(30, STORE_DEPTH) : $urandom_range(1, 8);
            room = budget - (words_sent - start);
            if (n > room) n = room;
            if (n < 1) n = 1;
            for (int i = 0; i < n; i++) begin
               send_word(rde_pkg::OP_PUSH, pick_value());
               case ($urandom_range(11))
                  0: send_word(rde_pkg::OP_REVERSE, rde_pkg::VALUE_W'($urandom));
                  1: send_word(rde_pkg::OP_DELETE, rde_pkg::VALUE_W'($urandom));
                  default: ;
               endcase
            end
            send_word(rde_pkg::OP_EMIT, rde_pkg::VALUE_W'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = rde_pkg::OP_CLEAR;
      req_value = '0;
      rsp_stall = 1'b0;
      exp_wr = '0;
      exp_rd = '0;
      words_sent = 0;
      failures = 0;
      send_idle_pct = 6;
      recv_idle_pct = 56;
      list_head = 0;
      list_count = 0;
      list_reversed = 1'b0;
      list_error = rde_pkg::ERR_NONE;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_errors();
      test_push_reverse_emit();
      test_random_lists(10);

      send_idle_pct = 56;
      recv_idle_pct = 6;
      test_full_store();
      test_random_lists(10);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_lists(10);

      @(negedge clock);
      req_valid <= 1'b0;
      while (exp_rd != exp_wr) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("PASS reversible_deque_engine");
      end else begin
         $display("FAIL reversible_deque_engine");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/rde_pkg.sv
hdl/rde_ram.sv
hdl/reversible_deque_engine.sv
dv/testbench.sv
